### src/rmsn_pkg.sv
// Shared types and constants for the RMS normalizer.
`default_nettype none
package rmsn_pkg;
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_ROOT,
		ST_NMUL1,
		ST_NMUL2,
		ST_NMUL3,
		ST_NOUT
	} state_t;

	localparam logic [31:0] EPS_RESET = 32'd4295;
	localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
	localparam logic [0:0] REG_EPSILON = 1'b0;
	localparam logic [0:0] REG_USE_GAIN = 1'b1;
endpackage
`default_nettype wire

### src/rmsn_divider.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module rmsn_divider (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] dividend,
	input  wire logic [63:0] divisor,
	output logic             done,
	output logic [63:0]      quotient
);
	logic [63:0] rem_q;
	logic [63:0] quo_q;
	logic [63:0] div_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [64:0] trial;

	assign trial = {rem_q, quo_q[63]} - {1'b0, div_q};
	assign quotient = quo_q;

	// Shift one dividend bit into the partial remainder each cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			if (!trial[64] || rem_q[63]) begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[62:0], quo_q[63]};
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

### src/rmsn_root.sv
// Integer square root, one result bit per cycle.
`default_nettype none
module rmsn_root (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] radicand,
	output logic             done,
	output logic [31:0]      root
);
	logic [63:0] x_q;
	logic [63:0] r_q;
	logic [63:0] bit_q;
	logic        busy_q;
	logic [63:0] sum;

	assign sum = r_q + bit_q;
	assign root = r_q[31:0];

	// Test one pair of radicand bits per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[1:0] != 2'b00) begin
				busy_q <= 1'b0;
				done <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= radicand;
			r_q <= '0;
			bit_q <= 64'h4000_0000_0000_0000;
		end else if (busy_q) begin
			if (x_q >= sum) begin
				x_q <= x_q - sum;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end
endmodule
`default_nettype wire

### src/rms_normalizer.sv
// Top level: RMS normalizer with two dividers, a root unit and a shared 32x32 multiplier.
// Accumulate sample: the sequencer stays idle, so accumulate transfers can follow back to back.
// Last accumulate sample: mean divide, reciprocal divide, square root and handoff registers
// run before the next transfer; the reciprocal divide is skipped when the mean is 0 or 1.
// Normalize sample: three multiplier passes then the output stage, which holds while the
// output is stalled; a new sample is taken only after it. Reset clears sums, count and the root.
`default_nettype none
module rms_normalizer #(
	parameter int MAX_ROW_WIDTH = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,  // sample[31:0], gain[63:32]
	input  wire logic        s_tuser,  // action
	input  wire logic        s_tlast,  // last
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,  // normalized
	output logic             m_tuser,  // clipped or sum saturated
	output logic             m_tlast,  // row_end
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	import rmsn_pkg::*;

	localparam int CW = $clog2(MAX_ROW_WIDTH + 1);

	state_t state_q, state_d;
	logic [31:0] eps_q;
	logic        use_gain_q;
	logic [63:0] sum_q;
	logic [CW-1:0] cnt_q;
	logic [31:0] inv_q;
	logic        sat_q;
	logic [31:0] a_q, g_q;
	logic        neg_q, last_q;
	logic [63:0] p_q, m_q;
	logic [63:0] prod;
	logic [31:0] mul_a, mul_b;
	logic [31:0] sa, ga;
	logic        sn, gn;
	logic [63:0] sq, sum_base, sum_new;
	logic        sum_ovf;
	logic        div_start, div_done, root_start, root_done;
	logic [63:0] quot, mean;
	logic [64:0] mean_w;
	logic [31:0] root;
	logic        take;
	logic [31:0] res;
	logic        clip;
	logic        rdiv_start;
	logic        rdiv_done;
	logic [63:0] rdiv_q, rdivisor_q;
	logic        mean_small_q;
	logic        div_done_d1_q;
	logic [63:0] rad;
	logic [63:0] rad_q;
	logic        rs_d1_q;
	logic [47:0] mm;
	logic        ng;

	rmsn_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(sum_q), .divisor({{(64-CW){1'b0}}, cnt_q}),
		.done(div_done), .quotient(quot)
	);

	assign mean_w = {1'b0, quot} + {33'd0, eps_q};
	assign mean = mean_w[64] ? 64'hFFFF_FFFF_FFFF_FFFF : mean_w[63:0];

	// Operand magnitudes.
	assign sn = s_tdata[31];
	assign sa = sn ? (~s_tdata[31:0] + 32'd1) : s_tdata[31:0];
	assign gn = use_gain_q ? s_tdata[63] : 1'b0;
	assign ga = !use_gain_q ? ONE_Q16 :
		(s_tdata[63] ? (~s_tdata[63:32] + 32'd1) : s_tdata[63:32]);

	// Shared multiplier.
	assign prod = {32'd0, mul_a} * {32'd0, mul_b};
	always_comb begin
		mul_a = a_q;
		mul_b = inv_q;
		if (state_q == ST_IDLE) begin
			mul_b = sa;
			mul_a = sa;
		end else if (state_q == ST_NMUL2) begin
			mul_a = p_q[31:0];
			mul_b = g_q;
		end else if (state_q == ST_NMUL3) begin
			mul_a = p_q[63:32];
			mul_b = g_q;
		end
	end

	assign sq = prod;
	assign sum_base = (cnt_q == '0) ? 64'd0 : sum_q;
	assign {sum_ovf, sum_new} = {1'b0, sum_base} + {1'b0, sq};

	assign take = s_tvalid && s_tready;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (take) begin
				if (s_tuser) state_d = ST_NMUL1;
				else if (s_tlast) state_d = ST_DIV;
			end
			ST_DIV: state_d = ST_ROOT;
			ST_ROOT: if (root_done) state_d = ST_IDLE;
			ST_NMUL1: state_d = ST_NMUL2;
			ST_NMUL2: state_d = ST_NMUL3;
			ST_NMUL3: state_d = ST_NOUT;
			ST_NOUT: if (!m_tvalid || m_tready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer; start the mean divide once the last sample is summed.
	always_comb begin
		s_tready = (state_q == ST_IDLE);
		div_start = 1'b0;
		unique case (state_q)
			ST_DIV: div_start = 1'b1;
			default: div_start = 1'b0;
		endcase
	end

	// Root stage: radicand is floor(2^64 / mean), then square root; a mean of 0 or 1
	// saturates the root.
	rmsn_divider u_rdiv (
		.clk(clk), .arst_n(arst_n), .start(rdiv_start),
		.dividend(64'hFFFF_FFFF_FFFF_FFFF), .divisor(rdivisor_q),
		.done(rdiv_done), .quotient(rdiv_q)
	);

	// A power of two divides 2^64 exactly, so its quotient gains one.
	assign rad = ((rdivisor_q & (rdivisor_q - 64'd1)) == 64'd0) ? rdiv_q + 64'd1 : rdiv_q;

	assign rdiv_start = div_done_d1_q && !mean_small_q;
	assign root_start = rdiv_done;

	rmsn_root u_root (
		.clk(clk), .arst_n(arst_n), .start(rs_d1_q), .radicand(rad_q),
		.done(root_done), .root(root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_done_d1_q <= 1'b0;
			rs_d1_q <= 1'b0;
		end else begin
			div_done_d1_q <= div_done;
			rs_d1_q <= root_start || (div_done_d1_q && mean_small_q);
		end
	end

	always_ff @(posedge clk) begin
		if (div_done) begin
			rdivisor_q <= mean;
			mean_small_q <= (mean <= 64'd1);
		end
		if (root_start) rad_q <= rad;
		else if (div_done_d1_q && mean_small_q) rad_q <= 64'hFFFF_FFFF_FFFF_FFFF;
	end

	// Product rounding and saturation.
	assign mm = m_q[63:16];
	assign ng = neg_q && (mm != '0);
	always_comb begin
		clip = 1'b0;
		res = mm[31:0];
		if (!ng && mm > 48'h7FFF_FFFF) begin
			res = 32'h7FFF_FFFF;
			clip = 1'b1;
		end else if (ng && mm > 48'h8000_0000) begin
			res = 32'h8000_0000;
			clip = 1'b1;
		end else if (ng) begin
			res = ~mm[31:0] + 32'd1;
		end
	end

	// Registers and datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			eps_q <= EPS_RESET;
			use_gain_q <= 1'b1;
			sum_q <= '0;
			cnt_q <= '0;
			inv_q <= '0;
			sat_q <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_EPSILON: eps_q <= cfg_data;
					REG_USE_GAIN: use_gain_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (root_done) begin
				inv_q <= root;
				sum_q <= '0;
				cnt_q <= '0;
			end else if (take && !s_tuser) begin
				if (cnt_q == '0) sat_q <= sum_ovf;
				else if (sum_ovf) sat_q <= 1'b1;
				sum_q <= sum_ovf ? 64'hFFFF_FFFF_FFFF_FFFF : sum_new;
				if (cnt_q < CW'(MAX_ROW_WIDTH)) cnt_q <= cnt_q + CW'(1);
			end
			if (state_q == ST_NOUT && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
			else if (m_tready) m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			a_q <= sa;
			g_q <= ga;
			neg_q <= sn != gn;
			last_q <= s_tlast;
		end
		if (state_q == ST_NMUL1) p_q <= prod;
		// Low half of the gain product plus the rounding half, then add the high half.
		if (state_q == ST_NMUL2) m_q <= {32'd0, prod[63:32]} + 64'h0000_8000;
		else if (state_q == ST_NMUL3) m_q <= m_q + prod;
		if (state_q == ST_NOUT && (!m_tvalid || m_tready)) begin
			m_tdata <= res;
			m_tuser <= clip || sat_q;
			m_tlast <= last_q;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> state_q == ST_IDLE)
		else $error("ready outside idle");
	assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> state_q == ST_ROOT)
		else $error("divide not started");
	assert property (@(posedge clk) disable iff (!arst_n)
		root_done |-> state_q == ST_ROOT)
		else $error("root done out of sequence");
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output dropped while stalled");
endmodule
`default_nettype wire
